FILE: rtl/core/float_fixed_wire_converter_macros.svh
// Assertion helpers for the converter RTL.
`ifndef FLOAT_FIXED_WIRE_CONVERTER_MACROS_SVH
`define FLOAT_FIXED_WIRE_CONVERTER_MACROS_SVH

// Antecedent implies consequent on the next edge, off during reset.
`define FFWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent on the same edge, off during reset.
`define FFWC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ffwc_pkg.sv
package ffwc_pkg;

    localparam logic CMD_FLT2FIX = 1'b0;
    localparam logic CMD_FIX2FLT = 1'b1;

    localparam logic [7:0] EXP_LIMIT = 8'd142;
    localparam logic [7:0] EXP_POINT = 8'd134;

    typedef struct packed {
        logic [31:0] result;
        logic        out_of_range;
    } conv_out_t;

endpackage

FILE: rtl/core/ffwc_convert.sv
// Combinational conversion datapath for both directions.
module ffwc_convert
(
    input  logic                command,
    input  logic [31:0]         value,
    output ffwc_pkg::conv_out_t conv
);

    // float to fixed
    logic        f_neg;
    logic [7:0]  f_ex;
    logic [7:0]  f_exe;
    logic [23:0] f_sig;
    logic [7:0]  f_rsh;
    logic [5:0]  f_lsh;
    logic [54:0] f_wide;
    logic [30:0] f_q;
    logic        f_g;
    logic        f_st;
    logic [30:0] f_mag;
    logic [31:0] f_res;
    logic        f_oor;

    always_comb
    begin
        f_neg = value[31];
        f_ex  = value[30:23];
        f_sig = (f_ex != 8'd0) ? {1'b1, value[22:0]} : {1'b0, value[22:0]};
        f_exe = (f_ex != 8'd0) ? f_ex : 8'd1;
        f_oor = (f_ex >= ffwc_pkg::EXP_LIMIT);
        f_lsh = 6'd0;
        f_rsh = 8'd0;
        if (f_exe >= ffwc_pkg::EXP_POINT)
            f_lsh = 6'(f_exe - ffwc_pkg::EXP_POINT);
        else
            f_rsh = ffwc_pkg::EXP_POINT - f_exe;
        // value with 24 guard bits below the binary point
        f_wide = ({31'd0, f_sig} << f_lsh) << 24;
        if (f_rsh > 8'd30)
            f_wide = 55'd0;
        else
            f_wide = f_wide >> f_rsh[4:0];
        // shifts of 25..30 lose bits beyond the guard range: sticky covers them
        f_q  = f_wide[54:24];
        f_g  = f_wide[23];
        f_st = (f_wide[22:0] != 23'd0)
            || ((f_rsh > 8'd24) && (f_rsh <= 8'd30)
                && ((f_sig & ((24'd1 << (f_rsh[4:0] - 5'd24)) - 24'd1)) != 24'd0));
        f_mag = f_q + 31'(f_g && (f_st || f_q[0]));
        f_res = {f_neg && (value[30:0] != 31'd0), f_mag};
        if (f_oor)
            f_res = 32'd0;
    end

    // fixed to float
    logic [30:0] x_mag;
    logic [4:0]  x_p;
    logic [30:0] x_norm;
    logic [23:0] x_sig;
    logic        x_g;
    logic        x_st;
    logic [24:0] x_rnd;
    logic [31:0] x_res;

    always_comb
    begin
        x_mag = value[30:0];
        x_p   = 5'd0;
        for (int i = 0; i < 31; i++)
            if (x_mag[i])
                x_p = 5'(i);
        x_norm = x_mag << (5'd30 - x_p);
        x_sig  = x_norm[30:7];
        x_g    = x_norm[6];
        x_st   = (x_norm[5:0] != 6'd0);
        x_rnd  = {1'b0, x_sig} + 25'(x_g && (x_st || x_sig[0]));
        // hidden bit of x_rnd carries into the exponent field
        x_res  = {1'b0, 8'({3'd0, x_p} + 8'd110), 23'd0} + {7'd0, x_rnd};
        x_res[31] = value[31];
        if (x_mag == 31'd0)
            x_res = {value[31], 31'd0};
    end

    always_comb
    begin
        unique case (command)
            ffwc_pkg::CMD_FLT2FIX:
            begin
                conv.result       = f_res;
                conv.out_of_range = f_oor;
            end
            ffwc_pkg::CMD_FIX2FLT:
            begin
                conv.result       = x_res;
                conv.out_of_range = 1'b0;
            end
            default:
            begin
                conv.result       = 32'd0;
                conv.out_of_range = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/float_fixed_wire_converter.sv
// channel | signals                   | direction
// in      | valid, stall, command/value | into block
// out     | out_valid, out_stall, result/out_of_range | out of block
// One item per cycle when not stalled; registers: input, then result.
// Conversion logic sits between the two registers; no state beyond them.
// rst_n clears only the valid flags.
// An output stall holds the result; input is taken when a stage frees up.
`include "float_fixed_wire_converter_macros.svh"
module float_fixed_wire_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic        command,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result,
    output logic        out_of_range
);

    logic        in_v_reg;
    logic        in_cmd_reg;
    logic [31:0] in_val_reg;
    logic        o_v_reg;
    ffwc_pkg::conv_out_t o_reg;
    ffwc_pkg::conv_out_t conv;
    logic        o_free;
    logic        in_free;

    ffwc_convert u_conv
    (
        .command (in_cmd_reg),
        .value   (in_val_reg),
        .conv    (conv)
    );

    assign o_free  = !o_v_reg || !out_stall;
    assign in_free = !in_v_reg || o_free;
    assign stall   = !in_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_v_reg <= valid;
            if (o_free)
                o_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && valid)
        begin
            in_cmd_reg <= command;
            in_val_reg <= value;
        end
        if (o_free && in_v_reg)
            o_reg <= conv;
    end

    assign out_valid    = o_v_reg;
    assign result       = o_reg.result;
    assign out_of_range = o_reg.out_of_range;

    `FFWC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result))
    `FFWC_ASSERT_SAME(a_oor_zero, clk, rst_n, out_valid && out_of_range, result == 32'd0)
    `FFWC_ASSERT_NEXT(a_move, clk, rst_n, in_v_reg && !stall && !out_stall, out_valid)

endmodule

FILE: verif/float_fixed_wire_converter_tb.sv
module float_fixed_wire_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic        oor;
    } conv_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic        command;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result;
    logic        out_of_range;

    conv_t  pending_conv[$];
    int     n_errors;
    bit     calm;

    float_fixed_wire_converter i_dut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .command(command), .value(value), .out_valid(out_valid),
        .out_stall(out_stall), .result(result), .out_of_range(out_of_range)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // round to nearest even after shifting right by sh
    function automatic logic [63:0] shift_rne(logic [63:0] v, int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh == 0)
            return v;
        q    = v >> sh;
        rem  = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    function automatic conv_t convert(logic cmd, logic [31:0] w);
        conv_t       r;
        logic [7:0]  ex;
        logic [63:0] sig;
        logic [63:0] mag;
        logic [30:0] fmag;
        int          sh;
        int          p;
        r = '0;
        if (cmd == ffwc_pkg::CMD_FLT2FIX)
        begin
            ex = w[30:23];
            if (ex >= ffwc_pkg::EXP_LIMIT)
            begin
                r.oor = 1'b1;
                return r;
            end
            if (ex != 0)
                sig = {40'd0, 1'b1, w[22:0]};
            else
            begin
                sig = {41'd0, w[22:0]};
                ex  = 8'd1;
            end
            sh = int'(ex) - int'(ffwc_pkg::EXP_POINT);
            if (sh >= 0)
                mag = sig << sh;
            else if (-sh >= 40)
                mag = '0;
            else
                mag = shift_rne(sig, -sh);
            r.word = {1'b0, mag[30:0]};
            if (w[31] && w[30:0] != 0)
                r.word[31] = 1'b1;
        end
        else
        begin
            fmag = w[30:0];
            if (fmag == 0)
            begin
                r.word = {w[31], 31'd0};
                return r;
            end
            p = 0;
            while (p < 30 && (fmag >> (p + 1)) != 0)
                p++;
            if (p <= 23)
                sig = {33'd0, fmag} << (23 - p);
            else
                sig = shift_rne({33'd0, fmag}, p - 23);
            r.word = {w[31], 31'd0} | ((32'(p + 110) << 23) + sig[31:0]);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic send_item(logic cmd, logic [31:0] w);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        valid   <= 1'b1;
        command <= cmd;
        value   <= w;
        pending_conv.push_back(convert(cmd, w));
        @(posedge clk);
        while (stall)
            @(posedge clk);
    endtask

    task automatic finish_items();
        valid <= 1'b0;
        @(posedge clk);
    endtask

    // output side stall bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        conv_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_conv.size() == 0)
            begin
                report_mismatch("unexpected item result", result, 32'd0);
            end
            else
            begin
                want = pending_conv.pop_front();
                if (result !== want.word)
                    report_mismatch("result", result, want.word);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", {31'd0, out_of_range},
                                    {31'd0, want.oor});
            end
        end
    end

    task automatic test_float_edges();
        logic [31:0] vals[$];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
                 32'h807f_ffff, 32'h3780_0000, 32'hb780_0000, 32'h3700_0000,
                 32'hb700_0001, 32'h3f80_0000, 32'hbfc0_0000, 32'h46ff_ffff,
                 32'hc6ff_ffff, 32'h4700_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0001, 32'h3f7f_ffff};
        foreach (vals[i])
            send_item(ffwc_pkg::CMD_FLT2FIX, vals[i]);
    endtask

    task automatic test_fixed_edges();
        logic [31:0] vals[$];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff,
                 32'hffff_ffff, 32'h0100_0001, 32'h0100_0003, 32'h0001_0000};
        foreach (vals[i])
            send_item(ffwc_pkg::CMD_FIX2FLT, vals[i]);
    endtask

    task automatic test_random(int count);
        logic [31:0] w;
        logic        cmd;
        repeat (count)
        begin
            cmd = 1'($urandom_range(0, 1));
            w   = $urandom;
            // bias floats toward the convertible exponent window
            if (cmd == ffwc_pkg::CMD_FLT2FIX && $urandom_range(0, 3) != 0)
                w[30:23] = 8'($urandom_range(95, 145));
            else if (cmd == ffwc_pkg::CMD_FIX2FLT && $urandom_range(0, 2) == 0)
                w = w >> $urandom_range(0, 31) | (w & 32'h8000_0000);
            send_item(cmd, w);
        end
    endtask

    initial
    begin
        int waited;
        n_errors  = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        valid     = 1'b0;
        command   = ffwc_pkg::CMD_FLT2FIX;
        value     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_float_edges();
        test_fixed_edges();
        test_random(650);
        calm = 1'b1;
        test_random(150);
        finish_items();
        waited = 0;
        while (pending_conv.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (n_errors == 0 && pending_conv.size() == 0)
            $display("float_fixed_wire_converter: match");
        else
            $display("float_fixed_wire_converter: mismatch");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("float_fixed_wire_converter: mismatch");
        $finish;
    end
endmodule
